>>> hw/rtl/klst_pkg.sv
// shared types and constants for the keyed latency statistics table
package klst_pkg;

	localparam int ENTRIES_DEF  = 64;
	localparam int KEY_BITS_DEF = 32;

	typedef enum logic [2:0] {
		KIND_RECORD   = 3'd0,
		KIND_REGISTER = 3'd1,
		KIND_UNREG    = 3'd2,
		KIND_QUERY    = 3'd3,
		KIND_CLEAR    = 3'd4
	} kind_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// one command as the front end hands it to the back end
	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] key;
		logic [31:0] sample;
	} cmd_t;

	// one result item
	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] calls;
		logic [31:0] avg;
		logic [31:0] mn;
		logic [31:0] mx;
	} res_t;

endpackage

>>> hw/rtl/klst_front.sv
// input stage and two-entry command queue
module klst_front #(
	parameter int KEY_BITS = klst_pkg::KEY_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [2:0]     in_kind,
	input  logic [31:0]    in_key,
	input  logic [31:0]    in_sample,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output klst_pkg::cmd_t cmd
);
	import klst_pkg::*;

	cmd_t       q_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	cmd_t       c_in;

	always_comb begin
		c_in = '0;
		c_in.kind = in_kind;
		for (int b = 0; b < 64; b++) begin
			if (b < KEY_BITS && b < 32) begin
				c_in.key[b] = in_key[b];
			end
		end
		c_in.sample = in_sample;
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) begin
				q_q[wr_q] <= c_in;
				wr_q <= ~wr_q;
			end
			if (cmd_valid && cmd_ready) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(cmd_valid && cmd_ready);
		end
	end

endmodule

>>> hw/rtl/klst_div.sv
// radix-2 restoring divider, 64 by 64, low 32 quotient bits
module klst_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [63:0] rem_q, quo_q, dvs_q;
	logic [6:0]  cnt_q;
	logic [64:0] trial;

	assign busy     = (cnt_q != 7'd0);
	assign quotient = quo_q[31:0];
	assign trial    = {rem_q, quo_q[63]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
			cnt_q <= 7'd64;
		end else if (busy) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
			cnt_q <= cnt_q - 7'd1;
		end
	end

endmodule

>>> hw/rtl/klst_back.sv
// slot table: key scan, read-modify-write of statistics, last-slot move on unregister, clear, query divide
module klst_back #(
	parameter int ENTRIES  = klst_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = klst_pkg::KEY_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  klst_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output klst_pkg::res_t res
);
	import klst_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_RD, S_UPD, S_MOVE_RD, S_MOVE_WR, S_CLR, S_DIV, S_DIVW, S_OUT
	} state_t;

	typedef struct packed {
		logic [63:0] calls;
		logic [63:0] total;
		logic [31:0] mn;
		logic [31:0] mx;
	} stat_t;

	logic [KEY_BITS-1:0] key_mem [ENTRIES];
	stat_t               st_mem  [ENTRIES];

	state_t              state_q;
	cmd_t                cmd_q;
	logic [CW-1:0]       used_q;
	logic [CW-1:0]       ptr_q;
	logic [IW-1:0]       hit_q;
	logic [KEY_BITS-1:0] key_rd_q;
	stat_t               st_rd_q;
	logic                key_ok_q;
	res_t                res_q;
	logic                div_start_q;
	logic                div_busy;
	logic [31:0]         div_quo;
	logic [KEY_BITS-1:0] cmd_key;
	logic [IW-1:0]       last_idx;

	assign cmd_key   = cmd_q.key[KEY_BITS-1:0];
	assign last_idx  = IW'(used_q - CW'(1));
	assign cmd_ready = (state_q == S_IDLE) && !res_valid;
	assign res_valid = (state_q == S_OUT);
	assign res       = res_q;

	klst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (st_rd_q.total),
		.divisor  (st_rd_q.calls),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	function automatic stat_t upd(stat_t s, logic [31:0] x);
		stat_t r;
		r = s;
		r.calls = s.calls + 64'd1;
		r.total = s.total + {32'd0, x};
		if (s.calls == 64'd0) begin
			r.mn = x;
			r.mx = x;
		end else begin
			if (x < s.mn) r.mn = x;
			if (x > s.mx) r.mx = x;
		end
		return r;
	endfunction

	// key and stats read, one port each, registered
	always_ff @(posedge clk) begin
		key_rd_q <= key_mem[(state_q == S_MOVE_RD) ? last_idx : ptr_q[IW-1:0]];
		st_rd_q  <= st_mem[(state_q == S_MOVE_RD) ? last_idx : hit_q];
		if (state_q == S_IDLE && cmd_valid && cmd.kind == KIND_REGISTER
				&& used_q != CW'(ENTRIES)) begin
			key_mem[used_q[IW-1:0]] <= cmd.key[KEY_BITS-1:0];
			st_mem[used_q[IW-1:0]]  <= '0;
		end else if (state_q == S_MOVE_WR) begin
			key_mem[hit_q] <= key_rd_q;
			st_mem[hit_q]  <= st_rd_q;
		end else if (state_q == S_UPD) begin
			st_mem[hit_q] <= upd(st_rd_q, cmd_q.sample);
		end else if (state_q == S_CLR) begin
			st_mem[ptr_q[IW-1:0]] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			ptr_q <= '0;
			hit_q <= '0;
			key_ok_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						cmd_q <= cmd;
						res_q <= '0;
						ptr_q <= '0;
						key_ok_q <= 1'b0;
						case (cmd.kind)
							KIND_RECORD, KIND_UNREG, KIND_QUERY: state_q <= S_SCAN;
							KIND_REGISTER: begin
								if (used_q == CW'(ENTRIES)) begin
									res_q.status <= ST_FULL;
								end else begin
									used_q <= used_q + CW'(1);
								end
								state_q <= S_OUT;
							end
							KIND_CLEAR: state_q <= S_CLR;
							default: state_q <= S_OUT;
						endcase
					end
				end
				// key read is registered: key_rd_q holds the key of the slot that ptr_q named in the previous cycle
				S_SCAN: begin
					if (key_ok_q && key_rd_q == cmd_key) begin
						hit_q <= IW'(ptr_q - CW'(1));
						state_q <= (cmd_q.kind == KIND_UNREG) ? S_MOVE_RD : S_RD;
					end else if (ptr_q >= used_q) begin
						res_q.status <= ST_NOT_FOUND;
						state_q <= S_OUT;
					end else begin
						ptr_q <= ptr_q + CW'(1);
						key_ok_q <= 1'b1;
					end
				end
				S_RD: begin
					state_q <= (cmd_q.kind == KIND_RECORD) ? S_UPD : S_DIV;
				end
				S_UPD: state_q <= S_OUT;
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				// key and stats of the last slot are on the read registers here
				S_MOVE_WR: begin
					used_q <= used_q - CW'(1);
					state_q <= S_OUT;
				end
				S_CLR: begin
					if (ptr_q + CW'(1) >= used_q) begin
						state_q <= S_OUT;
					end else begin
						ptr_q <= ptr_q + CW'(1);
					end
				end
				S_DIV: begin
					if (st_rd_q.calls == 64'd0) begin
						state_q <= S_OUT;
					end else begin
						res_q.calls <= st_rd_q.calls;
						res_q.mn <= st_rd_q.mn;
						res_q.mx <= st_rd_q.mx;
						div_start_q <= 1'b1;
						state_q <= S_DIVW;
					end
				end
				S_DIVW: begin
					if (!div_start_q && !div_busy) begin
						res_q.avg <= div_quo;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/keyed_latency_stats_table_top.sv
// keyed latency statistics table: ports, front queue and slot table
// record/unregister/query scan the slots one per cycle until a match or the last used slot
// query adds the bit-serial 64-bit divide; reset-stats clears the used slots one per cycle
// register and unknown kinds go from idle straight to the result; one item at a time in the table, two queued in front
// arst_n empties the table and the queue; slot memories are not cleared
module keyed_latency_stats_table_top #(
	parameter int ENTRIES  = klst_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = klst_pkg::KEY_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,  // hook_id[31:0], latency[63:32], zero pad
	input  logic [2:0]   s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [167:0] m_tdata   // status[1:0], call_count[65:2], average_cycles[97:66],
	                               // min_latency[129:98], max_latency[161:130], zero pad
);
	import klst_pkg::*;

	logic cmd_valid, cmd_ready;
	cmd_t cmd;
	res_t res;

	klst_front #(.KEY_BITS(KEY_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_key    (s_tdata[31:0]),
		.in_sample (s_tdata[63:32]),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	klst_back #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {6'd0, res.mx, res.mn, res.avg, res.calls, res.status};

endmodule

>>> tb/tb.sv
// testbench for the keyed latency statistics table: table of directed transfers, fill and drain, then random traffic
`timescale 1ns / 1ps

module tb;
	import klst_pkg::*;

	localparam int SLOTS = 64;
	localparam int N_RANDOM = 434;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] key;
		logic [31:0] sample;
		bit          typed;
		logic [1:0]  status;
	} stim_row_t;

	typedef struct {
		logic [1:0]  status;
		logic [63:0] calls;
		logic [31:0] avg;
		logic [31:0] mn;
		logic [31:0] mx;
	} stat_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [71:0]  s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [167:0] m_tdata;

	keyed_latency_stats_table_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// shadow of the slot table
	logic [31:0] key_mem [SLOTS];
	logic [63:0] calls_mem [SLOTS];
	logic [63:0] total_mem [SLOTS];
	logic [31:0] min_mem [SLOTS];
	logic [31:0] max_mem [SLOTS];
	int          n_used;

	stat_res_t   pending_stats [$];
	stim_row_t   directed [$];
	int          errors;
	bit          quiet;
	bit          hold_off;
	int          idle_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int lookup_slot(logic [31:0] key);
		for (int i = 0; i < n_used; i++)
			if (key_mem[i] == key)
				return i;
		return -1;
	endfunction

	function automatic stat_res_t apply_item(logic [2:0] kind, logic [31:0] key,
			logic [31:0] sample);
		stat_res_t r;
		int idx;
		r = '{default: '0};
		r.status = ST_OK;
		case (kind)
			KIND_RECORD: begin
				idx = lookup_slot(key);
				if (idx < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					if (calls_mem[idx] == 0) begin
						min_mem[idx] = sample;
						max_mem[idx] = sample;
					end else begin
						if (sample < min_mem[idx]) min_mem[idx] = sample;
						if (sample > max_mem[idx]) max_mem[idx] = sample;
					end
					calls_mem[idx] += 64'd1;
					total_mem[idx] += {32'd0, sample};
				end
			end
			KIND_REGISTER: begin
				if (n_used >= SLOTS) begin
					r.status = ST_FULL;
				end else begin
					key_mem[n_used] = key;
					calls_mem[n_used] = '0;
					total_mem[n_used] = '0;
					min_mem[n_used] = '0;
					max_mem[n_used] = '0;
					n_used++;
				end
			end
			KIND_UNREG: begin
				idx = lookup_slot(key);
				if (idx < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					key_mem[idx] = key_mem[n_used-1];
					calls_mem[idx] = calls_mem[n_used-1];
					total_mem[idx] = total_mem[n_used-1];
					min_mem[idx] = min_mem[n_used-1];
					max_mem[idx] = max_mem[n_used-1];
					n_used--;
				end
			end
			KIND_QUERY: begin
				idx = lookup_slot(key);
				if (idx < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.calls = calls_mem[idx];
					if (calls_mem[idx] != 0) begin
						r.avg = 32'(total_mem[idx] / calls_mem[idx]);
						r.mn = min_mem[idx];
						r.mx = max_mem[idx];
					end
				end
			end
			KIND_CLEAR: begin
				for (int i = 0; i < n_used; i++) begin
					calls_mem[i] = '0;
					total_mem[i] = '0;
					min_mem[i] = '0;
					max_mem[i] = '0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(logic [2:0] kind, logic [31:0] key, logic [31:0] sample,
			bit typed, logic [1:0] typed_status);
		stat_res_t r;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {8'd0, sample, key};
		do @(posedge clk); while (!s_tready);
		r = apply_item(kind, key, sample);
		if (typed && r.status != typed_status)
			$display("%0t: directed row status predicted %0d, table says %0d",
				$time, r.status, typed_status);
		if (typed)
			r.status = typed_status;
		pending_stats.push_back(r);
	endtask

	// keys come from a small pool so lookups hit often
	function automatic logic [31:0] pool_key();
		case ($urandom_range(0, 3))
			0: return 32'hFFFF_FFFF;
			1: return 32'h0000_0000;
			default: return 32'hA5A5_0000 | 32'($urandom_range(0, 11));
		endcase
	endfunction

	// receiver with random stalls and one long hold-off
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		stat_res_t want;
		stat_res_t got;
		if (m_tvalid && m_tready) begin
			got.status = m_tdata[1:0];
			got.calls = m_tdata[65:2];
			got.avg = m_tdata[97:66];
			got.mn = m_tdata[129:98];
			got.mx = m_tdata[161:130];
			if (pending_stats.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				errors++;
			end else begin
				want = pending_stats.pop_front();
				if (got.status != want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						got.status);
					errors++;
				end
				if (got.calls != want.calls) begin
					$display("%0t: call_count expected %0d actual %0d", $time, want.calls,
						got.calls);
					errors++;
				end
				if (got.avg != want.avg) begin
					$display("%0t: average expected %0d actual %0d", $time, want.avg, got.avg);
					errors++;
				end
				if (got.mn != want.mn) begin
					$display("%0t: min expected %0d actual %0d", $time, want.mn, got.mn);
					errors++;
				end
				if (got.mx != want.mx) begin
					$display("%0t: max expected %0d actual %0d", $time, want.mx, got.mx);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("keyed_latency_stats_table_top: mismatch");
			$finish;
		end
	end

	initial begin
		int kind_pick;
		logic [2:0] kind;
		errors = 0;
		n_used = 0;
		quiet = 1'b0;
		hold_off = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;

		// directed rows: kind, key, sample, typed?, typed status
		directed.push_back('{KIND_QUERY, 32'h1, 0, 1, ST_NOT_FOUND});
		directed.push_back('{KIND_RECORD, 32'h1, 5, 1, ST_NOT_FOUND});
		directed.push_back('{KIND_UNREG, 32'h1, 0, 1, ST_NOT_FOUND});
		directed.push_back('{KIND_REGISTER, 32'hFFFF_FFFF, 0, 1, ST_OK});
		directed.push_back('{KIND_QUERY, 32'hFFFF_FFFF, 0, 0, 0});
		directed.push_back('{KIND_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0});
		directed.push_back('{KIND_RECORD, 32'hFFFF_FFFF, 32'h0, 0, 0});
		directed.push_back('{KIND_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0});
		directed.push_back('{KIND_QUERY, 32'hFFFF_FFFF, 0, 0, 0});
		directed.push_back('{KIND_REGISTER, 32'h0, 0, 1, ST_OK});
		directed.push_back('{KIND_REGISTER, 32'h0, 0, 1, ST_OK});
		directed.push_back('{KIND_RECORD, 32'h0, 32'h5555_AAAA, 0, 0});
		directed.push_back('{KIND_QUERY, 32'h0, 0, 0, 0});
		directed.push_back('{3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0});
		directed.push_back('{3'd7, 32'h0, 0, 0, 0});
		directed.push_back('{KIND_UNREG, 32'hFFFF_FFFF, 0, 1, ST_OK});
		directed.push_back('{KIND_QUERY, 32'h0, 0, 0, 0});
		directed.push_back('{KIND_CLEAR, 32'h0, 0, 1, ST_OK});
		directed.push_back('{KIND_QUERY, 32'h0, 0, 0, 0});
		directed.push_back('{KIND_UNREG, 32'h0, 0, 1, ST_OK});
		directed.push_back('{KIND_UNREG, 32'h0, 0, 1, ST_OK});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i].kind, directed[i].key, directed[i].sample,
				directed[i].typed, directed[i].status);

		// fill to capacity, one beyond, then drain some
		for (int i = 0; i < SLOTS + 1; i++)
			send_item(KIND_REGISTER, pool_key(), $urandom, 0, 0);
		hold_off = 1'b1;
		for (int i = 0; i < 30; i++)
			send_item(KIND_UNREG, pool_key(), $urandom, 0, 0);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n > N_RANDOM - 80)
				quiet = 1'b1;
			kind_pick = $urandom_range(0, 99);
			if (kind_pick < 50) kind = KIND_RECORD;
			else if (kind_pick < 64) kind = KIND_REGISTER;
			else if (kind_pick < 76) kind = KIND_UNREG;
			else if (kind_pick < 93) kind = KIND_QUERY;
			else if (kind_pick < 96) kind = KIND_CLEAR;
			else kind = 3'($urandom_range(5, 7));
			if ($urandom_range(0, 9) == 0)
				send_item(kind, $urandom, $urandom, 0, 0);
			else
				send_item(kind, pool_key(), $urandom_range(0, 3) == 0 ? $urandom :
					32'($urandom_range(0, 1000)), 0, 0);
		end
		s_tvalid <= 1'b0;

		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_stats.size() == 0)
			$display("keyed_latency_stats_table_top: match");
		else
			$display("keyed_latency_stats_table_top: mismatch");
		$finish;
	end

endmodule
